/* rtl/k_nearest_max_heap_select_top_macros.svh */
// Assertion macros shared by the k-nearest selection checker.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef K_NEAREST_MAX_HEAP_SELECT_TOP_MACROS_SVH
`define K_NEAREST_MAX_HEAP_SELECT_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define KNNHS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset
`define KNNHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/knnhs_pkg.sv */
// Types and constants of the k-nearest max-heap selector.
// Used by the top level and the checker; no dependencies.
`default_nettype none

package knnhs_pkg;

  localparam int DIST_W  = 32;
  localparam int ID_W    = 20;
  localparam int COUNT_W = 6;
  localparam int ACT_W   = 2;
  localparam int ENTRY_W = DIST_W + ID_W;

  // Action codes of an input item
  localparam logic [ACT_W-1:0] ACT_START = 2'd0;
  localparam logic [ACT_W-1:0] ACT_OFFER = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  // Reset value of the wanted-count register
  localparam logic [COUNT_W-1:0] WANT_RESET = 6'd32;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [DIST_W-1:0] dist_key;
    logic [ID_W-1:0]   photon_id;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0]  radius_key;
    logic [COUNT_W-1:0] held_count;
    logic [DIST_W-1:0]  entry_dist;
    logic [ID_W-1:0]    entry_id;
    logic               entry_valid;
    logic               last_entry;
  } out_item_t;

  // One heap slot as stored in memory
  typedef struct packed {
    logic [DIST_W-1:0] dist_val;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b00000000001,
    ST_EXEC     = 11'b00000000010,
    ST_B_LOAD   = 11'b00000000100,
    ST_B_KEY    = 11'b00000001000,
    ST_S_RD     = 11'b00000010000,
    ST_S_CMP    = 11'b00000100000,
    ST_R_RD     = 11'b00001000000,
    ST_R_CMP    = 11'b00010000000,
    ST_OUT_RD   = 11'b00100000000,
    ST_OUT_LOAD = 11'b01000000000,
    ST_FIN      = 11'b10000000000
  } state_t;

endpackage

`default_nettype wire

/* rtl/knnhs_ram.sv */
// Generic RAM: one write port, two read ports with registered read data.
// Read data holds while its read enable is low. No dependencies.
`default_nettype none

module knnhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       re_a,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_a,
  output logic      [WIDTH-1:0]           rdata_a,
  input  wire logic                       re_b,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_b,
  output logic      [WIDTH-1:0]           rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports
  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

/* rtl/k_nearest_max_heap_select_top.sv */
// Start, append, unused items: the result is registered after the execute and finish states.
// Readout: first entry after a slot read, then one per cycle unless stalled. Heap offer: root
// read and compare, then a child read and a compare-write per level (log2 K at most), a write if
// the key sinks to a leaf; the first past K first builds the heap, sifting down each inner node.
// Throughput: one item at a time; the sift loop over one heap memory sets the rate.
// Reset: control state clears at once; the store is not cleared (slots written before use).
`default_nettype none

module k_nearest_max_heap_select_top #(
  parameter int MAX_NEAREST = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire knnhs_pkg::in_item_t           in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output knnhs_pkg::out_item_t               out_data,
  input  wire logic                          cfg_we,
  input  wire logic [knnhs_pkg::COUNT_W-1:0] cfg_wdata
);

  import knnhs_pkg::*;

  localparam int AW = $clog2(MAX_NEAREST);
  localparam int SW = $clog2(MAX_NEAREST + 1);
  localparam int CW = SW + 1;

  // Control state
  state_t             state_r,  state_nxt;
  logic [COUNT_W-1:0] want_r;
  logic [SW-1:0]      held_r,   held_nxt;
  logic               ready_r,  ready_nxt;
  logic [DIST_W-1:0]  radius_r, radius_nxt;
  logic               mode_rep_r, mode_rep_nxt;
  logic               out_valid_r;

  // Working registers
  in_item_t           item_r,  item_nxt;
  entry_t             key_r,   key_nxt;
  logic [SW-1:0]      pos_r,   pos_nxt;
  logic [CW-1:0]      child_r, child_nxt;
  logic               right_ok_r, right_ok_nxt;
  logic [SW-1:0]      bk_r,    bk_nxt;
  logic [SW-1:0]      rd_i_r,  rd_i_nxt;
  out_item_t          out_r;

  // Memory ports
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  entry_t             mem_wdata;
  logic               mem_re_a, mem_re_b;
  logic [AW-1:0]      mem_raddr_a, mem_raddr_b;
  logic [ENTRY_W-1:0] mem_rdata_a, mem_rdata_b;
  entry_t             ent_a, ent_b;

  // Helpers
  logic [SW-1:0]      k_eff;
  logic [CW-1:0]      child_c;
  logic [CW-1:0]      pick_pos;
  entry_t             pick_e;
  logic               stop;
  logic               sift_done;
  logic               sift_wr;
  logic [SW-1:0]      rd_next;
  logic               out_free;
  logic               out_load;
  out_item_t          out_val;

  knnhs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_NEAREST)
  ) u_heap_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re_a    (mem_re_a),
    .raddr_a (mem_raddr_a),
    .rdata_a (mem_rdata_a),
    .re_b    (mem_re_b),
    .raddr_b (mem_raddr_b),
    .rdata_b (mem_rdata_b)
  );

  assign ent_a    = entry_t'(mem_rdata_a);
  assign ent_b    = entry_t'(mem_rdata_b);
  assign child_c  = {pos_r, 1'b0};
  assign rd_next  = rd_i_r + 1'b1;
  assign out_free = !out_valid_r || !out_stall;

  // Saturate the wanted count to 1..MAX_NEAREST
  always_comb begin
    if (want_r == '0) begin
      k_eff = SW'(1);
    end else if (int'(want_r) > MAX_NEAREST) begin
      k_eff = SW'(MAX_NEAREST);
    end else begin
      k_eff = SW'(want_r);
    end
  end

  // Pick the larger child; ties keep the left one
  always_comb begin
    if (right_ok_r && (ent_a.dist_val < ent_b.dist_val)) begin
      pick_e   = ent_b;
      pick_pos = child_r + 1'b1;
    end else begin
      pick_e   = ent_a;
      pick_pos = child_r;
    end
    // Build stops on a tie, replacement sinks past it
    stop = mode_rep_r ? (key_r.dist_val > pick_e.dist_val) :
                        (key_r.dist_val >= pick_e.dist_val);
  end

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    held_nxt     = held_r;
    ready_nxt    = ready_r;
    radius_nxt   = radius_r;
    mode_rep_nxt = mode_rep_r;
    item_nxt     = item_r;
    key_nxt      = key_r;
    pos_nxt      = pos_r;
    child_nxt    = child_r;
    right_ok_nxt = right_ok_r;
    bk_nxt       = bk_r;
    rd_i_nxt     = rd_i_r;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re_a     = 1'b0;
    mem_raddr_a  = '0;
    mem_re_b     = 1'b0;
    mem_raddr_b  = '0;
    sift_done    = 1'b0;
    sift_wr      = 1'b0;
    out_load     = 1'b0;
    out_val      = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (item_r.action)
          ACT_START: begin
            held_nxt   = '0;
            ready_nxt  = 1'b0;
            radius_nxt = item_r.dist_key;
            state_nxt  = ST_FIN;
          end
          ACT_OFFER: begin
            if (held_r < k_eff) begin
              // Append to the next free slot
              mem_we    = 1'b1;
              mem_waddr = AW'(held_r);
              mem_wdata = '{dist_val: item_r.dist_key, id: item_r.photon_id};
              held_nxt  = held_r + 1'b1;
              state_nxt = ST_FIN;
            end else if (!ready_r) begin
              // Heapify from the last inner node down to the root
              mode_rep_nxt = 1'b0;
              if ((held_r >> 1) == '0) begin
                ready_nxt = 1'b1;
                state_nxt = ST_R_RD;
              end else begin
                bk_nxt    = held_r >> 1;
                state_nxt = ST_B_LOAD;
              end
            end else begin
              state_nxt = ST_R_RD;
            end
          end
          ACT_READ: begin
            if (held_r == '0) begin
              state_nxt = ST_FIN;
            end else begin
              rd_i_nxt  = '0;
              state_nxt = ST_OUT_RD;
            end
          end
          default: begin
            state_nxt = ST_FIN;
          end
        endcase
      end

      ST_B_LOAD: begin
        mem_re_a    = 1'b1;
        mem_raddr_a = AW'(bk_r - 1'b1);
        state_nxt   = ST_B_KEY;
      end

      ST_B_KEY: begin
        key_nxt   = ent_a;
        pos_nxt   = bk_r;
        state_nxt = ST_S_RD;
      end

      ST_R_RD: begin
        mem_re_a     = 1'b1;
        mem_raddr_a  = '0;
        mode_rep_nxt = 1'b1;
        state_nxt    = ST_R_CMP;
      end

      ST_R_CMP: begin
        if (item_r.dist_key >= ent_a.dist_val) begin
          // Not nearer than the farthest held: reject
          radius_nxt = ent_a.dist_val;
          state_nxt  = ST_FIN;
        end else begin
          key_nxt   = '{dist_val: item_r.dist_key, id: item_r.photon_id};
          pos_nxt   = SW'(1);
          state_nxt = ST_S_RD;
        end
      end

      ST_S_RD: begin
        if (child_c <= {1'b0, held_r}) begin
          // Fetch the left child and, if present, the right child of the current position
          mem_re_a     = 1'b1;
          mem_raddr_a  = AW'(child_c - 1'b1);
          right_ok_nxt = child_c < {1'b0, held_r};
          mem_re_b     = child_c < {1'b0, held_r};
          mem_raddr_b  = (child_c < {1'b0, held_r}) ? AW'(child_c) : '0;
          child_nxt    = child_c;
          state_nxt    = ST_S_CMP;
        end else begin
          // Leaf reached: drop the key here
          mem_we    = 1'b1;
          mem_waddr = AW'(pos_r - 1'b1);
          mem_wdata = key_r;
          sift_wr   = 1'b1;
          sift_done = 1'b1;
        end
      end

      ST_S_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(pos_r - 1'b1);
        sift_wr   = 1'b1;
        if (stop) begin
          mem_wdata = key_r;
          sift_done = 1'b1;
        end else begin
          // Promote the child and descend
          mem_wdata = pick_e;
          pos_nxt   = pick_pos[SW-1:0];
          state_nxt = ST_S_RD;
        end
      end

      ST_OUT_RD: begin
        mem_re_a    = 1'b1;
        mem_raddr_a = AW'(rd_i_r);
        state_nxt   = ST_OUT_LOAD;
      end

      ST_OUT_LOAD: begin
        if (out_free) begin
          out_load = 1'b1;
          out_val  = '{radius_key:  radius_r,
                       held_count:  COUNT_W'(held_r),
                       entry_dist:  ent_a.dist_val,
                       entry_id:    ent_a.id,
                       entry_valid: 1'b1,
                       last_entry:  rd_next == held_r};
          if (rd_next == held_r) begin
            state_nxt = ST_IDLE;
          end else begin
            // Fetch the next slot while this one goes out
            rd_i_nxt    = rd_next;
            mem_re_a    = 1'b1;
            mem_raddr_a = AW'(rd_next);
          end
        end
      end

      ST_FIN: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_val   = '{radius_key:  radius_r,
                        held_count:  COUNT_W'(held_r),
                        entry_dist:  '0,
                        entry_id:    '0,
                        entry_valid: 1'b0,
                        last_entry:  1'b1};
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // New root during replacement sets the radius
    if (sift_wr && mode_rep_r && (mem_waddr == '0)) begin
      radius_nxt = mem_wdata.dist_val;
    end

    // Advance to the next node, or finish
    if (sift_done) begin
      if (mode_rep_r) begin
        state_nxt = ST_FIN;
      end else if (bk_r == SW'(1)) begin
        ready_nxt = 1'b1;
        state_nxt = ST_R_RD;
      end else begin
        bk_nxt    = bk_r - 1'b1;
        state_nxt = ST_B_LOAD;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      want_r      <= WANT_RESET;
      held_r      <= '0;
      ready_r     <= 1'b0;
      radius_r    <= '0;
      mode_rep_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      held_r     <= held_nxt;
      ready_r    <= ready_nxt;
      radius_r   <= radius_nxt;
      mode_rep_r <= mode_rep_nxt;
      if (cfg_we) begin
        want_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers and output payload
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    key_r      <= key_nxt;
    pos_r      <= pos_nxt;
    child_r    <= child_nxt;
    right_ok_r <= right_ok_nxt;
    bk_r       <= bk_nxt;
    rd_i_r     <= rd_i_nxt;
    if (out_load) begin
      out_r <= out_val;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* rtl/knnhs_checker.sv */
// Port-level checker for the k-nearest selector, bound to the top level.
// Depends on knnhs_pkg and the assertion macros header.
`default_nettype none
`include "k_nearest_max_heap_select_top_macros.svh"

module knnhs_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire knnhs_pkg::out_item_t out_data
);

  import knnhs_pkg::*;

  // A stalled result holds
  `KNNHS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // One item at a time: a transfer closes the input
  `KNNHS_ASSERT_NEXT(a_in_close, in_valid && !in_stall, in_stall, "input open right after a transfer")

  // An emitted entry implies something is held
  `KNNHS_ASSERT_NOW(a_entry_held, out_valid && out_data.entry_valid, out_data.held_count != '0, "entry emitted with nothing held")

  // A result without an entry is the only and final one, with zero payload
  `KNNHS_ASSERT_NOW(a_plain_last, out_valid && !out_data.entry_valid, out_data.last_entry && (out_data.entry_dist == '0) && (out_data.entry_id == '0), "plain result malformed")

endmodule

bind k_nearest_max_heap_select_top knnhs_checker u_knnhs_checker (.*);

`default_nettype wire
